[sv/lca_pkg.sv]
// shared constants and types for the lowest common ancestor block
package lca_pkg;
    localparam int NodeBits  = 10;
    localparam int MaxNodes  = 1 << NodeBits;
    localparam int Levels    = 10;
    localparam int LevelBits = 4;
    localparam int LinkBits  = NodeBits + 1;
    localparam int CountBits = 11;
    localparam int JumpDepth = MaxNodes * Levels;
    localparam int JumpAddrBits = 14;

    localparam logic [1:0] MODE_LOAD  = 2'd0;
    localparam logic [1:0] MODE_BUILD = 2'd1;
    localparam logic [1:0] MODE_QUERY = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_BLD_RD0,
        ST_BLD_WR0,
        ST_BLD_RDA,
        ST_BLD_RDB,
        ST_BLD_WR,
        ST_Q_RDD,
        ST_Q_ORD,
        ST_Q_LIFT,
        ST_Q_LIFTW,
        ST_Q_JRD,
        ST_Q_JRD2,
        ST_Q_JW,
        ST_Q_PAR,
        ST_Q_PARW,
        ST_OUT
    } t_state;

    function automatic logic [JumpAddrBits-1:0] jaddr(input logic [NodeBits-1:0] n,
                                                      input logic [LevelBits-1:0] l);
        jaddr = JumpAddrBits'(n) * JumpAddrBits'(Levels) + JumpAddrBits'(l);
    endfunction
endpackage

[sv/lca_ram.sv]
// generic single-port-write, single-port-read ram with registered read
module lca_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

[sv/lowest_common_ancestor_lifting.sv]
// top level of the lowest common ancestor by binary lifting block
// usage:
//   s_axis carries one command transaction: mode 0 loads a node's parent and
//   depth, mode 1 builds the jump table, mode 2 queries two nodes, mode 3 is dropped
//   m_axis carries one result transaction per query: ancestor and no_common
//   the config channel writes node_count (levels built) while the block idles
// operation:
//   a load is written as it is accepted and the next command can follow right away
//   a query reads both depths, runs a lifting pass over the levels with one extra
//   step per lift taken, then a joint pass that reads both jumps per level, and
//   ends with a parent read; when the lifted node meets the other one the joint
//   pass is skipped
//   a build walks every node for level 0 (read the parent, write the link) and
//   then every node for each higher level (read two links, write one), as set
//   by the single read port of the jump table memory
//   one command is worked at a time; s_axis_tready is low while busy
// reset: control state returns to idle and node_count to 1024; the stores are undefined until written
// stall: the result is held in an output register until m_axis_tready
module lowest_common_ancestor_lifting (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // mode[1:0], node_a[11:2], node_b[21:12], has_parent[22], node_depth[32:23]
    input  logic [39:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // ancestor[9:0], no_common[10]
    output logic [15:0] m_axis_tdata,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [10:0] i_cfg_data
);
    localparam int NB = lca_pkg::NodeBits;
    localparam int LB = lca_pkg::LinkBits;
    localparam int AB = lca_pkg::JumpAddrBits;
    localparam int VB = lca_pkg::NodeBits;  // valid bit position in a link

    lca_pkg::t_state r_state, n_state;

    logic [lca_pkg::CountBits-1:0] r_count;
    logic [NB-1:0] r_p, n_p, r_q, n_q;
    logic [NB-1:0] r_dp, n_dp, r_dq, n_dq;
    logic [NB-1:0] r_i, n_i;                 // build node index
    logic [lca_pkg::LevelBits-1:0] r_lv, n_lv;
    logic [LB-1:0] r_jp, n_jp;
    logic [NB-1:0] r_anc, n_anc;
    logic r_nc, n_nc;

    // memories: node store holds {depth, parent link}, jump table holds links
    logic nd_we, jmp_we;
    logic [NB-1:0] nd_ra;
    logic [LB+NB-1:0] nd_wd, nd_rd;
    logic [LB-1:0] par_rd, jmp_wd, jmp_rd;
    logic [NB-1:0] dep_rd;
    logic [AB-1:0] jmp_wa, jmp_ra;

    logic [1:0] in_mode;
    logic [NB-1:0] in_a, in_b, in_d;
    logic in_hp, s_acc;

    lca_ram #(.Width(LB + NB), .Depth(lca_pkg::MaxNodes)) u_nd (
        .i_clk(i_clk), .i_we(nd_we), .i_waddr(in_a), .i_wdata(nd_wd),
        .i_raddr(nd_ra), .o_rdata(nd_rd));
    lca_ram #(.Width(LB), .Depth(lca_pkg::JumpDepth)) u_jmp (
        .i_clk(i_clk), .i_we(jmp_we), .i_waddr(jmp_wa), .i_wdata(jmp_wd),
        .i_raddr(jmp_ra), .o_rdata(jmp_rd));

    assign par_rd = nd_rd[LB-1:0];
    assign dep_rd = nd_rd[LB+NB-1:LB];

    assign in_mode = s_axis_tdata[1:0];
    assign in_a    = s_axis_tdata[11:2];
    assign in_b    = s_axis_tdata[21:12];
    assign in_hp   = s_axis_tdata[22];
    assign in_d    = s_axis_tdata[32:23];
    assign s_acc   = s_axis_tvalid && s_axis_tready;

    assign s_axis_tready = (r_state == lca_pkg::ST_IDLE);
    assign o_cfg_ready   = (r_state == lca_pkg::ST_IDLE);
    assign m_axis_tvalid = (r_state == lca_pkg::ST_OUT);
    assign m_axis_tdata  = {5'd0, r_nc, r_anc};

    // level lv is active in a build when 2^lv <= node_count
    logic lv_on;
    assign lv_on = ((lca_pkg::CountBits+1)'(1) << r_lv) <= {1'b0, r_count};
    // lift step test on the stored depth of p: dp >= dq + 2^lv
    logic lift_go;
    assign lift_go = {1'b0, dep_rd} >= ({1'b0, r_dq} + ((NB+1)'(1) << r_lv));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lca_pkg::ST_IDLE;
            r_count <= 11'd1024;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                r_count <= i_cfg_data;
            end
        end
        r_p <= n_p; r_q <= n_q; r_dp <= n_dp; r_dq <= n_dq;
        r_i <= n_i; r_lv <= n_lv; r_jp <= n_jp; r_anc <= n_anc; r_nc <= n_nc;
    end

    // next state and datapath registers
    always_comb begin
        n_state = r_state;
        n_p = r_p; n_q = r_q; n_dp = r_dp; n_dq = r_dq;
        n_i = r_i; n_lv = r_lv; n_jp = r_jp; n_anc = r_anc; n_nc = r_nc;
        case (r_state)
            lca_pkg::ST_IDLE: begin
                if (s_acc) begin
                    n_p = in_a; n_q = in_b; n_i = '0; n_lv = '0;
                    case (in_mode)
                        lca_pkg::MODE_BUILD: n_state = lca_pkg::ST_BLD_RD0;
                        lca_pkg::MODE_QUERY: n_state = lca_pkg::ST_Q_RDD;
                        default: n_state = lca_pkg::ST_IDLE;
                    endcase
                end
            end
            lca_pkg::ST_BLD_RD0: n_state = lca_pkg::ST_BLD_WR0;
            lca_pkg::ST_BLD_WR0: begin
                n_i = r_i + 1'b1;
                if (r_i == '1) begin
                    n_lv = 4'd1;
                    n_state = lca_pkg::ST_BLD_RDA;
                end else begin
                    n_state = lca_pkg::ST_BLD_RD0;
                end
            end
            lca_pkg::ST_BLD_RDA: n_state = lca_pkg::ST_BLD_RDB;
            lca_pkg::ST_BLD_RDB: begin
                n_jp = jmp_rd;
                n_state = lca_pkg::ST_BLD_WR;
            end
            lca_pkg::ST_BLD_WR: begin
                n_i = r_i + 1'b1;
                if (r_i == '1) begin
                    n_lv = r_lv + 1'b1;
                    n_state = (r_lv == 4'(lca_pkg::Levels - 1)) ? lca_pkg::ST_IDLE
                                                                 : lca_pkg::ST_BLD_RDA;
                end else begin
                    n_state = lca_pkg::ST_BLD_RDA;
                end
            end
            lca_pkg::ST_Q_RDD: begin
                // depth of the first node is back, the second is being read
                n_dp = dep_rd;
                n_state = lca_pkg::ST_Q_ORD;
            end
            lca_pkg::ST_Q_ORD: begin
                // order so that p is the deeper node
                if (r_dp < dep_rd) begin
                    n_p = r_q; n_q = r_p; n_dq = r_dp;
                end else begin
                    n_dq = dep_rd;
                end
                n_lv = 4'(lca_pkg::Levels - 1);
                n_state = lca_pkg::ST_Q_LIFT;
            end
            lca_pkg::ST_Q_LIFT: begin
                if (lift_go) begin
                    n_state = lca_pkg::ST_Q_LIFTW;
                end else if (r_lv == '0) begin
                    n_lv = 4'(lca_pkg::Levels - 1);
                    if (r_p == r_q) begin
                        n_anc = r_p; n_nc = 1'b0; n_state = lca_pkg::ST_OUT;
                    end else begin
                        n_state = lca_pkg::ST_Q_JRD;
                    end
                end else begin
                    n_lv = r_lv - 1'b1;
                end
            end
            lca_pkg::ST_Q_LIFTW: begin
                if (!jmp_rd[VB]) begin
                    n_anc = '0; n_nc = 1'b1; n_state = lca_pkg::ST_OUT;
                end else begin
                    // each level steps at most once, then the next level down
                    n_p = jmp_rd[NB-1:0];
                    if (r_lv == '0) begin
                        n_lv = 4'(lca_pkg::Levels - 1);
                        if (jmp_rd[NB-1:0] == r_q) begin
                            n_anc = jmp_rd[NB-1:0]; n_nc = 1'b0;
                            n_state = lca_pkg::ST_OUT;
                        end else begin
                            n_state = lca_pkg::ST_Q_JRD;
                        end
                    end else begin
                        n_lv = r_lv - 1'b1;
                        n_state = lca_pkg::ST_Q_LIFT;
                    end
                end
            end
            lca_pkg::ST_Q_JRD: n_state = lca_pkg::ST_Q_JRD2;
            lca_pkg::ST_Q_JRD2: begin
                n_jp = jmp_rd;
                n_state = lca_pkg::ST_Q_JW;
            end
            lca_pkg::ST_Q_JW: begin
                if (r_jp[VB] && jmp_rd[VB] && (r_jp != jmp_rd)) begin
                    n_p = r_jp[NB-1:0];
                    n_q = jmp_rd[NB-1:0];
                end
                if (r_lv == '0) begin
                    n_state = lca_pkg::ST_Q_PAR;
                end else begin
                    n_lv = r_lv - 1'b1;
                    n_state = lca_pkg::ST_Q_JRD;
                end
            end
            lca_pkg::ST_Q_PAR: n_state = lca_pkg::ST_Q_PARW;
            lca_pkg::ST_Q_PARW: begin
                n_nc = !par_rd[VB];
                n_anc = par_rd[VB] ? par_rd[NB-1:0] : '0;
                n_state = lca_pkg::ST_OUT;
            end
            lca_pkg::ST_OUT: begin
                if (m_axis_tready) begin
                    n_state = lca_pkg::ST_IDLE;
                end
            end
            default: n_state = lca_pkg::ST_IDLE;
        endcase
    end

    // memory control outputs
    always_comb begin
        nd_we = 1'b0; jmp_we = 1'b0;
        nd_wd = {in_d, (in_hp ? {1'b1, in_b} : LB'(0))};
        nd_ra = r_p;
        jmp_wa = lca_pkg::jaddr(r_i, r_lv);
        jmp_wd = '0;
        jmp_ra = lca_pkg::jaddr(r_p, r_lv);
        case (r_state)
            lca_pkg::ST_IDLE: begin
                if (s_acc && in_mode == lca_pkg::MODE_LOAD) begin
                    nd_we = 1'b1;
                end
                nd_ra = in_a;
            end
            lca_pkg::ST_BLD_RD0: nd_ra = r_i;
            lca_pkg::ST_BLD_WR0: begin
                jmp_we = 1'b1; jmp_wd = par_rd;
            end
            lca_pkg::ST_BLD_RDA: jmp_ra = lca_pkg::jaddr(r_i, r_lv - 1'b1);
            lca_pkg::ST_BLD_RDB: jmp_ra = lca_pkg::jaddr(jmp_rd[NB-1:0], r_lv - 1'b1);
            lca_pkg::ST_BLD_WR: begin
                jmp_we = 1'b1;
                jmp_wd = (lv_on && r_jp[VB]) ? jmp_rd : '0;
            end
            lca_pkg::ST_Q_RDD: nd_ra = r_q;
            // keep the depth of the deeper node on the read port for the lift test
            lca_pkg::ST_Q_ORD: nd_ra = (r_dp < dep_rd) ? r_q : r_p;
            lca_pkg::ST_Q_LIFT: jmp_ra = lca_pkg::jaddr(r_p, r_lv);
            lca_pkg::ST_Q_LIFTW: nd_ra = jmp_rd[NB-1:0];
            lca_pkg::ST_Q_JRD: jmp_ra = lca_pkg::jaddr(r_p, r_lv);
            lca_pkg::ST_Q_JRD2: jmp_ra = lca_pkg::jaddr(r_q, r_lv);
            lca_pkg::ST_Q_PAR: nd_ra = r_p;
            default: ;
        endcase
    end
endmodule

[tb/lowest_common_ancestor_lifting_test.sv]
// testbench for the lowest common ancestor by binary lifting block
`timescale 1ns / 1ps

module lowest_common_ancestor_lifting_test;
    // unused command code, the block must swallow it without a result
    localparam logic [1:0] MODE_NONE = 2'd3;
    localparam int PERIOD      = 4;
    localparam int STALL_LIMIT = 200000;  // watchdog limit, well above a full build
    localparam int SETTLE      = 100;     // quiet cycles after a drain
    localparam int HOLD_LEN    = 400;     // long receiver hold-off

    typedef enum {
        K_CMD,
        K_CFG,
        K_DRAIN,
        K_HOLD,
        K_IDLE
    } t_step_kind;

    typedef struct {
        t_step_kind kind;
        logic [1:0] mode;
        logic [9:0] a;
        logic [9:0] b;
        logic       hp;
        logic [9:0] d;
        logic [10:0] cnt;
        int         idle_s;
        int         idle_r;
    } t_step;

    typedef struct {
        logic [9:0] anc;
        logic       nc;
    } t_lca_answer;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [10:0] i_cfg_data = '0;

    lowest_common_ancestor_lifting DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    always #(PERIOD / 2) i_clk = ~i_clk;

    // stimulus plan and the answers still owed by the block
    t_step       plan_q[$];
    t_lca_answer answer_q[$];
    t_step       cur_cmd;
    int          answers_owed = 0;   // answers predicted so far
    int          answers_seen = 0;   // answers received so far
    int          errors = 0;
    int          send_idle = 0;
    int          recv_idle = 0;
    int          pause_cnt = 0;
    logic        hold_req = 1'b0;

    // predictor copy of the block state
    logic [10:0] link_mem[lca_pkg::MaxNodes];
    logic [9:0]  depth_mem[lca_pkg::MaxNodes];
    logic [10:0] jump_mem[lca_pkg::MaxNodes][lca_pkg::Levels];
    logic [10:0] level_count = 11'd1024;

    // shape of the forest as the generator built it
    int          shape_depth[lca_pkg::MaxNodes];
    int          deepest;

    function automatic void rebuild_jumps();
        logic [10:0] up;
        logic [10:0] v;
        logic        on;
        for (int i = 0; i < lca_pkg::MaxNodes; i++) jump_mem[i][0] = link_mem[i];
        for (int j = 1; j < lca_pkg::Levels; j++) begin
            on = (1 << j) <= int'(level_count);
            for (int i = 0; i < lca_pkg::MaxNodes; i++) begin
                up = jump_mem[i][j-1];
                v = '0;
                if (on && up[10]) v = jump_mem[up[9:0]][j-1];
                jump_mem[i][j] = v;
            end
        end
    endfunction

    // lowest common ancestor link, valid bit clear when none
    function automatic logic [10:0] lift_lca(input logic [9:0] pa, input logic [9:0] qa);
        logic [9:0]  p;
        logic [9:0]  q;
        logic [10:0] k;
        logic [10:0] jp;
        logic [10:0] jq;
        p = pa;
        q = qa;
        if (depth_mem[p] < depth_mem[q]) begin
            p = qa;
            q = pa;
        end
        // lift the deeper node to the depth of the other
        for (int i = lca_pkg::Levels - 1; i >= 0; i--) begin
            if (int'(depth_mem[p]) >= int'(depth_mem[q]) + (1 << i)) begin
                k = jump_mem[p][i];
                if (!k[10]) return '0;  // broken chain on the way up
                p = k[9:0];
            end
        end
        if (p == q) return {1'b1, p};
        // lift both while their ancestors differ
        for (int i = lca_pkg::Levels - 1; i >= 0; i--) begin
            jp = jump_mem[p][i];
            jq = jump_mem[q][i];
            if (jp[10] && jq[10] && jp != jq) begin
                p = jp[9:0];
                q = jq[9:0];
            end
        end
        return link_mem[p];
    endfunction

    // ---------------- plan builders ----------------
    function automatic void push_cmd(input logic [1:0] mode, input int a, input int b,
                                     input logic hp, input int d);
        t_step s;
        s = '{kind: K_CMD, mode: mode, a: a[9:0], b: b[9:0], hp: hp, d: d[9:0],
              cnt: '0, idle_s: 0, idle_r: 0};
        plan_q.insert(plan_q.size(), s);
    endfunction

    function automatic void push_ctl(input t_step_kind kind, input int cnt,
                                     input int is, input int ir);
        t_step s;
        s = '{kind: kind, mode: MODE_NONE, a: '0, b: '0, hp: 1'b0, d: '0,
              cnt: cnt[10:0], idle_s: is, idle_r: ir};
        plan_q.insert(plan_q.size(), s);
    endfunction

    // pick a query pair, half of them close together so they often share a tree
    function automatic void push_random_query();
        int a;
        int b;
        a = $urandom_range(lca_pkg::MaxNodes - 1);
        if ($urandom_range(1)) b = $urandom_range(lca_pkg::MaxNodes - 1);
        else b = (a + $urandom_range(40)) % lca_pkg::MaxNodes;
        if ($urandom_range(1)) push_cmd(lca_pkg::MODE_QUERY, a, b, 1'b0, 0);
        else push_cmd(lca_pkg::MODE_QUERY, b, a, 1'b0, 0);
    endfunction

    // re-load one node: mostly a consistent move, sometimes a root or garbage depth
    function automatic void push_random_reload();
        int n;
        int p;
        int r;
        n = $urandom_range(lca_pkg::MaxNodes - 1);
        r = $urandom_range(99);
        if (r < 70 && n > 0) begin
            p = $urandom_range(n - 1);
            shape_depth[n] = shape_depth[p] + 1;
            push_cmd(lca_pkg::MODE_LOAD, n, p, 1'b1, shape_depth[n]);
        end else if (r < 85) begin
            shape_depth[n] = 0;
            push_cmd(lca_pkg::MODE_LOAD, n, $urandom_range(lca_pkg::MaxNodes - 1), 1'b0, 0);
        end else begin
            shape_depth[n] = $urandom_range(1023);
            push_cmd(lca_pkg::MODE_LOAD, n, $urandom_range(lca_pkg::MaxNodes - 1), 1'b1,
                     shape_depth[n]);
        end
    endfunction

    // ---------------- driver ----------------
    always @(posedge i_clk) begin : drive_blk
        t_step       s;
        t_lca_answer ans;
        logic [10:0] r;
        logic        nxt_sv;
        logic        nxt_cv;
        logic        nxt_hold;
        nxt_sv = s_axis_tvalid;
        nxt_cv = i_cfg_valid;
        nxt_hold = 1'b0;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            i_cfg_valid <= 1'b0;
            hold_req <= 1'b0;
        end else begin
            // predict on the accepted command transaction
            if (s_axis_tvalid && s_axis_tready) begin
                nxt_sv = 1'b0;
                case (cur_cmd.mode)
                    lca_pkg::MODE_LOAD: begin
                        link_mem[cur_cmd.a] = cur_cmd.hp ? {1'b1, cur_cmd.b} : 11'd0;
                        depth_mem[cur_cmd.a] = cur_cmd.d;
                    end
                    lca_pkg::MODE_BUILD: rebuild_jumps();
                    lca_pkg::MODE_QUERY: begin
                        r = lift_lca(cur_cmd.a, cur_cmd.b);
                        if (r[10]) begin
                            ans.anc = r[9:0];
                            ans.nc = 1'b0;
                        end else begin
                            ans.anc = 10'd0;
                            ans.nc = 1'b1;
                        end
                        answer_q.insert(answer_q.size(), ans);
                        answers_owed <= answers_owed + 1;
                    end
                    default: ;
                endcase
            end
            if (i_cfg_valid && o_cfg_ready) begin
                level_count = i_cfg_data;
                nxt_cv = 1'b0;
            end
            // fetch the next step once nothing is in flight
            if (!nxt_sv && !nxt_cv) begin
                if (pause_cnt != 0) begin
                    pause_cnt <= pause_cnt - 1;
                end else if (plan_q.size() != 0) begin
                    case (plan_q[0].kind)
                        K_CMD: begin
                            if ($urandom_range(99) >= send_idle) begin
                                s = plan_q.pop_front();
                                cur_cmd <= s;
                                nxt_sv = 1'b1;
                                s_axis_tdata <= {7'd0, s.d, s.hp, s.b, s.a, s.mode};
                            end
                        end
                        K_CFG: begin
                            s = plan_q.pop_front();
                            nxt_cv = 1'b1;
                            i_cfg_data <= s.cnt;
                        end
                        K_DRAIN: begin
                            // sender pauses until every answer is back
                            if (answer_q.size() == 0) begin
                                s = plan_q.pop_front();
                                pause_cnt <= SETTLE;
                            end
                        end
                        K_HOLD: begin
                            s = plan_q.pop_front();
                            nxt_hold = 1'b1;
                        end
                        K_IDLE: begin
                            s = plan_q.pop_front();
                            send_idle <= s.idle_s;
                            recv_idle <= s.idle_r;
                        end
                        default: ;
                    endcase
                end
            end
            s_axis_tvalid <= nxt_sv;
            i_cfg_valid <= nxt_cv;
            hold_req <= nxt_hold;
        end
    end

    // ---------------- monitor ----------------
    int hold_cnt = 0;

    always @(posedge i_clk) begin : watch_blk
        t_lca_answer want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                answers_seen <= answers_seen + 1;
                if (answer_q.size() == 0) begin
                    $display("%0t: unexpected result transaction, actual anc=%0d nc=%0b",
                             $time, m_axis_tdata[9:0], m_axis_tdata[10]);
                    errors++;
                end else begin
                    want = answer_q.pop_front();
                    if (m_axis_tdata[9:0] !== want.anc || m_axis_tdata[10] !== want.nc) begin
                        $display("%0t: mismatch, expected anc=%0d nc=%0b actual anc=%0d nc=%0b",
                                 $time, want.anc, want.nc, m_axis_tdata[9:0],
                                 m_axis_tdata[10]);
                        errors++;
                    end
                end
            end
            // long hold-off lets the held result block the input side
            if (hold_req) hold_cnt <= HOLD_LEN;
            else if (hold_cnt != 0) hold_cnt <= hold_cnt - 1;
            m_axis_tready <= (hold_cnt == 0 && !hold_req && $urandom_range(99) >= recv_idle);
        end
    end

    // ---------------- watchdog ----------------
    int quiet_cycles = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (i_cfg_valid && o_cfg_ready) || pause_cnt != 0) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
            $display("== FAIL ==");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ---------------- stimulus ----------------
    initial begin : stim_blk
        int p;
        int a;
        int counts[8];
        counts = '{1, 2, 3, 512, 1023, 16, 1024, 5};

        // random forest with long chains, node 0 a root, a few more roots
        deepest = 0;
        push_ctl(K_IDLE, 0, 0, 0);
        push_ctl(K_CFG, 1024, 0, 0);
        for (int i = 0; i < lca_pkg::MaxNodes; i++) begin
            if (i == 0 || $urandom_range(99) == 0) begin
                shape_depth[i] = 0;
                push_cmd(lca_pkg::MODE_LOAD, i, $urandom_range(lca_pkg::MaxNodes - 1), 1'b0, 0);
            end else begin
                p = $urandom_range(i - 1, (i > 3) ? i - 3 : 0);
                shape_depth[i] = shape_depth[p] + 1;
                push_cmd(lca_pkg::MODE_LOAD, i, p, 1'b1, shape_depth[i]);
            end
            if (shape_depth[i] > shape_depth[deepest]) deepest = i;
        end
        push_cmd(lca_pkg::MODE_BUILD, 0, 0, 1'b0, 0);

        // directed queries: root alone, same node, neighbouring nodes, extremes
        push_cmd(lca_pkg::MODE_QUERY, 0, 0, 1'b0, 0);
        push_cmd(lca_pkg::MODE_QUERY, 700, 700, 1'b0, 0);
        push_cmd(lca_pkg::MODE_QUERY, 1023, 1022, 1'b0, 0);
        push_cmd(lca_pkg::MODE_QUERY, 1022, 1023, 1'b0, 0);
        push_cmd(lca_pkg::MODE_QUERY, deepest, 0, 1'b0, 0);
        push_cmd(lca_pkg::MODE_QUERY, 0, deepest, 1'b0, 0);
        push_cmd(lca_pkg::MODE_QUERY, deepest, 1023, 1'b0, 0);
        push_cmd(lca_pkg::MODE_QUERY, 1, 1023, 1'b0, 0);
        push_cmd(MODE_NONE, 1023, 1023, 1'b1, 1023);
        push_cmd(lca_pkg::MODE_QUERY, 512, 511, 1'b0, 0);
        push_cmd(lca_pkg::MODE_QUERY, 341, 682, 1'b0, 0);
        push_ctl(K_DRAIN, 0, 0, 0);

        // random phases: new level count, some reloads, a build, queries
        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: push_ctl(K_IDLE, 0, 0, 0);
                1: push_ctl(K_IDLE, 0, 55, 0);
                2: push_ctl(K_IDLE, 0, 0, 55);
                default: push_ctl(K_IDLE, 0, 18, 18);
            endcase
            push_ctl(K_CFG, (ph == 7) ? $urandom_range(1, 1024) : counts[ph], 0, 0);
            for (int k = 0; k < 30; k++) push_random_reload();
            push_cmd(lca_pkg::MODE_BUILD, 0, 0, 1'b0, 0);
            if (ph == 1 || ph == 5) push_ctl(K_HOLD, 0, 0, 0);
            for (int k = 0; k < 60; k++) begin
                if ($urandom_range(49) == 0) begin
                    a = $urandom_range(lca_pkg::MaxNodes - 1);
                    push_cmd(MODE_NONE, a, $urandom_range(lca_pkg::MaxNodes - 1),
                             $urandom_range(1), $urandom_range(1023));
                end else if ($urandom_range(29) == 0) begin
                    // reload without rebuild, the table goes stale on purpose
                    push_random_reload();
                end
                push_random_query();
            end
            push_random_query();
            push_ctl(K_DRAIN, 0, 0, 0);
        end

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (plan_q.size() != 0 || s_axis_tvalid || i_cfg_valid
               || answers_owed != answers_seen || pause_cnt != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);

        if (answer_q.size() != 0)
            $display("%0t: %0d expected results never arrived", $time, answer_q.size());
        if (errors == 0 && answer_q.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule

[filelist.f]
sv/lca_pkg.sv
sv/lca_ram.sv
sv/lowest_common_ancestor_lifting.sv
tb/lowest_common_ancestor_lifting_test.sv
